### rtl/fwpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpd_pkg
// Shared types and constants for the four-wheel PD speed loop.
// ----------------------------------------------------------------------------
package fwpd_pkg;

   localparam int WHEELS    = 4;
   localparam int SPEED_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int LIM_W     = 10;
   localparam int CTRL_W    = 21;
   localparam int CTRL_FRAC = 10;
   localparam int DUTY_W    = 11;
   localparam int CMP_W     = 10;
   localparam int ODO_W     = 48;
   localparam int DUTY_MAX  = 1000;
   localparam int STAGES    = 6;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RAW      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLR_CTRL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLR_ODO  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_KP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIM  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REVM = 2'd3;

   localparam logic [GAIN_W-1:0] KP_RESET   = 16'd25600;
   localparam logic [GAIN_W-1:0] KD_RESET   = 16'd51200;
   localparam logic [LIM_W-1:0]  LIM_RESET  = 10'd1000;
   localparam logic [WHEELS-1:0] REVM_RESET = 4'd5;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [SPEED_W-1:0] set_lf;
      logic signed [SPEED_W-1:0] set_rf;
      logic signed [SPEED_W-1:0] set_lr;
      logic signed [SPEED_W-1:0] set_rr;
      logic signed [SPEED_W-1:0] meas_lf;
      logic signed [SPEED_W-1:0] meas_rf;
      logic signed [SPEED_W-1:0] meas_lr;
      logic signed [SPEED_W-1:0] meas_rr;
   } fwpd_req_type;

   typedef struct packed {
      logic [CMP_W-1:0]        fwd_lf;
      logic [CMP_W-1:0]        rev_lf;
      logic [CMP_W-1:0]        fwd_rf;
      logic [CMP_W-1:0]        rev_rf;
      logic [CMP_W-1:0]        fwd_lr;
      logic [CMP_W-1:0]        rev_lr;
      logic [CMP_W-1:0]        fwd_rr;
      logic [CMP_W-1:0]        rev_rr;
      logic signed [ODO_W-1:0] distance;
   } fwpd_rsp_type;

   // ld[k]: stage k loads this cycle; cmd[k]: command held in stage k
   // (cmd[0] is the incoming item's command)
   typedef struct packed {
      logic [STAGES:1]                ld;
      logic [STAGES-1:0][CMD_W-1:0]   cmd;
   } fwpd_ctl_type;

endpackage

### rtl/fwpd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpd_lane
// One wheel: error, PD products, rounding, clamped accumulate, duty apply
// and split into forward/reverse compare values. Six-stage pipeline.
// ----------------------------------------------------------------------------
module fwpd_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fwpd_pkg::fwpd_ctl_type               ctl,
   input  logic [fwpd_pkg::GAIN_W-1:0]          kp_gain,
   input  logic [fwpd_pkg::GAIN_W-1:0]          kd_gain,
   input  logic [fwpd_pkg::LIM_W-1:0]           duty_lim,
   input  logic                                 rev_bit,
   input  logic signed [fwpd_pkg::SPEED_W-1:0]  set_val,
   input  logic signed [fwpd_pkg::SPEED_W-1:0]  speed,
   output logic [fwpd_pkg::CMP_W-1:0]           fwd,
   output logic [fwpd_pkg::CMP_W-1:0]           rev
);
   import fwpd_pkg::*;

   localparam int ERR_W = SPEED_W + 1;
   localparam int DIF_W = SPEED_W + 2;
   localparam int PK_W  = GAIN_W + 1 + ERR_W;
   localparam int PD_W  = GAIN_W + 1 + DIF_W;
   localparam int SUM_W = PD_W + 1;
   localparam int RND_W = SUM_W - 8;
   localparam int DLT_W = RND_W + 1;
   localparam int ACC_W = DLT_W + 1;
   localparam int Q_W   = CTRL_W - CTRL_FRAC;
   localparam int RAW_W = SPEED_W + 1;
   localparam logic signed [RAW_W-1:0] DMAX = RAW_W'(DUTY_MAX);

   // stage 1
   logic signed [ERR_W-1:0]   s1_err_in, s1_err_ff;
   logic signed [DIF_W-1:0]   s1_dif_in, s1_dif_ff;
   logic signed [SPEED_W-1:0] s1_set_ff;
   logic signed [ERR_W-1:0]   prev_in, prev_ff;
   // stage 2
   logic signed [GAIN_W:0]    kps, kds;
   logic signed [PK_W-1:0]    s2_pk_in, s2_pk_ff;
   logic signed [PD_W-1:0]    s2_pd_in, s2_pd_ff;
   logic signed [SPEED_W-1:0] s2_set_ff;
   // stage 3
   logic signed [SUM_W-1:0]   s3_sum_in, s3_sum_ff;
   logic signed [SPEED_W-1:0] s3_set_ff;
   // stage 4
   logic                      rnd_neg;
   logic [SUM_W-1:0]          rnd_mag, rnd_add;
   logic [RND_W-1:0]          rnd_q;
   logic signed [DLT_W-1:0]   s4_dlt_in, s4_dlt_ff;
   logic signed [SPEED_W-1:0] s4_set_ff;
   // stage 5
   logic signed [ACC_W-1:0]   acc_sum, lim_pos, lim_neg, acc_clip;
   logic signed [CTRL_W-1:0]  s5_acc_in, s5_acc_ff;
   logic signed [CTRL_W-1:0]  ctrl_in, ctrl_ff;
   logic signed [SPEED_W-1:0] s5_set_ff;
   // stage 6
   logic                      trn_neg;
   logic [CTRL_W-1:0]         trn_mag;
   logic [Q_W-1:0]            trn_q;
   logic signed [RAW_W-1:0]   dsel, dneg, dclip;
   logic signed [DUTY_W-1:0]  duty_in, duty_ff;
   logic signed [DUTY_W-1:0]  duty_abs;
   logic [CMP_W-1:0]          fwd_in, rev_in, fwd_ff, rev_ff;

   // stage 1: error and error change
   always_comb begin
      s1_err_in = ERR_W'(set_val) - ERR_W'(speed);
      s1_dif_in = DIF_W'(s1_err_in) - DIF_W'(prev_ff);
      prev_in   = prev_ff;
      if (ctl.cmd[0] == CMD_TICK) begin
         prev_in = s1_err_in;
      end else if (ctl.cmd[0] == CMD_CLR_CTRL) begin
         prev_in = '0;
      end
   end

   // stage 2: the two gain products
   always_comb begin
      kps      = $signed({1'b0, kp_gain});
      kds      = $signed({1'b0, kd_gain});
      s2_pk_in = PK_W'(kps) * PK_W'(s1_err_ff);
      s2_pd_in = PD_W'(kds) * PD_W'(s1_dif_ff);
   end

   // stage 3: sum
   assign s3_sum_in = SUM_W'(s2_pk_ff) + SUM_W'(s2_pd_ff);

   // stage 4: drop 8 fraction bits, round half away from zero
   always_comb begin
      rnd_neg   = s3_sum_ff[SUM_W-1];
      rnd_mag   = rnd_neg ? SUM_W'(-s3_sum_ff) : SUM_W'(s3_sum_ff);
      rnd_add   = rnd_mag + SUM_W'(128);
      rnd_q     = rnd_add[SUM_W-1:8];
      s4_dlt_in = rnd_neg ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
   end

   // stage 5: accumulate and clamp
   always_comb begin
      acc_sum  = ACC_W'(ctrl_ff) + ACC_W'(s4_dlt_ff);
      lim_pos  = $signed(ACC_W'({duty_lim, {CTRL_FRAC{1'b0}}}));
      lim_neg  = -lim_pos;
      acc_clip = acc_sum;
      if (acc_sum > lim_pos) begin
         acc_clip = lim_pos;
      end else if (acc_sum < lim_neg) begin
         acc_clip = lim_neg;
      end
      s5_acc_in = acc_clip[CTRL_W-1:0];
      ctrl_in   = ctrl_ff;
      if (ctl.cmd[4] == CMD_TICK) begin
         ctrl_in = s5_acc_in;
      end else if (ctl.cmd[4] == CMD_CLR_CTRL) begin
         ctrl_in = '0;
      end
   end

   // stage 6: integer duty, mounting direction, clamp, split
   always_comb begin
      trn_neg = s5_acc_ff[CTRL_W-1];
      trn_mag = trn_neg ? CTRL_W'(-s5_acc_ff) : CTRL_W'(s5_acc_ff);
      trn_q   = trn_mag[CTRL_W-1:CTRL_FRAC];
      if (ctl.cmd[5] == CMD_RAW) begin
         dsel = RAW_W'(s5_set_ff);
      end else begin
         dsel = trn_neg ? -$signed(RAW_W'(trn_q)) : $signed(RAW_W'(trn_q));
      end
      dneg  = rev_bit ? -dsel : dsel;
      dclip = dneg;
      if (dneg > DMAX) begin
         dclip = DMAX;
      end else if (dneg < -DMAX) begin
         dclip = -DMAX;
      end
      duty_in = duty_ff;
      if (ctl.cmd[5] == CMD_TICK || ctl.cmd[5] == CMD_RAW) begin
         duty_in = dclip[DUTY_W-1:0];
      end
      duty_abs = -duty_in;
      fwd_in   = (duty_in > 0) ? duty_in[CMP_W-1:0] : '0;
      rev_in   = (duty_in < 0) ? duty_abs[CMP_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         ctrl_ff <= '0;
         duty_ff <= '0;
      end else begin
         if (ctl.ld[1]) begin
            prev_ff <= prev_in;
         end
         if (ctl.ld[5]) begin
            ctrl_ff <= ctrl_in;
         end
         if (ctl.ld[6]) begin
            duty_ff <= duty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld[1]) begin
         s1_err_ff <= s1_err_in;
         s1_dif_ff <= s1_dif_in;
         s1_set_ff <= set_val;
      end
      if (ctl.ld[2]) begin
         s2_pk_ff  <= s2_pk_in;
         s2_pd_ff  <= s2_pd_in;
         s2_set_ff <= s1_set_ff;
      end
      if (ctl.ld[3]) begin
         s3_sum_ff <= s3_sum_in;
         s3_set_ff <= s2_set_ff;
      end
      if (ctl.ld[4]) begin
         s4_dlt_ff <= s4_dlt_in;
         s4_set_ff <= s3_set_ff;
      end
      if (ctl.ld[5]) begin
         s5_acc_ff <= s5_acc_in;
         s5_set_ff <= s4_set_ff;
      end
      if (ctl.ld[6]) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign fwd = fwd_ff;
   assign rev = rev_ff;

endmodule

### rtl/fwpd_odo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpd_odo
// Merge stage: sums the wheel speeds of a tick and advances the wrapping
// odometer in the last stage, in item order with the lanes.
// ----------------------------------------------------------------------------
module fwpd_odo (
   input  logic                                              clock,
   input  logic                                              reset,
   input  fwpd_pkg::fwpd_ctl_type                            ctl,
   input  logic [fwpd_pkg::WHEELS-1:0][fwpd_pkg::SPEED_W-1:0] speed,
   output logic signed [fwpd_pkg::ODO_W-1:0]                 distance
);
   import fwpd_pkg::*;

   localparam int SUM_W = SPEED_W + $clog2(WHEELS) + 1;

   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] s1_sum_ff, s2_sum_ff, s3_sum_ff, s4_sum_ff, s5_sum_ff;
   logic signed [ODO_W-1:0] odo_in, odo_ff;

   always_comb begin
      sum_in = '0;
      for (int w = 0; w < WHEELS; w++) begin
         sum_in = sum_in + SUM_W'($signed(speed[w]));
      end
   end

   always_comb begin
      odo_in = odo_ff;
      if (ctl.cmd[5] == CMD_TICK) begin
         odo_in = odo_ff + ODO_W'(s5_sum_ff);
      end else if (ctl.cmd[5] == CMD_CLR_ODO) begin
         odo_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odo_ff <= '0;
      end else if (ctl.ld[6]) begin
         odo_ff <= odo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld[1]) begin
         s1_sum_ff <= sum_in;
      end
      if (ctl.ld[2]) begin
         s2_sum_ff <= s1_sum_ff;
      end
      if (ctl.ld[3]) begin
         s3_sum_ff <= s2_sum_ff;
      end
      if (ctl.ld[4]) begin
         s4_sum_ff <= s3_sum_ff;
      end
      if (ctl.ld[5]) begin
         s5_sum_ff <= s4_sum_ff;
      end
   end

   // odo_ff changes only when the output stage loads, so it is the result
   assign distance = odo_ff;

endmodule

### rtl/four_wheel_pd_speed_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_pd_speed_loop
// Four-wheel incremental PD speed loop with H-bridge compare split and
// odometer. Four wheel lanes in parallel, merged into one result item.
//
// Pipeline: 6 stages (error, products, sum, round, accumulate,
//   apply/output); a result is valid once its item is held in the output stage.
// Throughput: one item per cycle unless rsp_ready stalls; stages advance on
//   their own, so input enters while a result waits if any stage has room.
// Reset: synchronous; clears pipeline valids, controller state, duties and
//   odometer, and loads the register defaults.
// ----------------------------------------------------------------------------
module four_wheel_pd_speed_loop (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fwpd_pkg::fwpd_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fwpd_pkg::fwpd_rsp_type               rsp_data,
   input  logic                                 csr_write_en,
   input  logic [fwpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fwpd_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import fwpd_pkg::*;

   logic [GAIN_W-1:0] kp_in, kp_ff, kd_in, kd_ff;
   logic [LIM_W-1:0]  lim_in, lim_ff;
   logic [WHEELS-1:0] revm_in, revm_ff;

   logic [STAGES:1]            v_in, v_ff, rdy, ld;
   logic [STAGES-1:1][CMD_W-1:0] cmd_ff;
   fwpd_ctl_type               ctl;

   logic [WHEELS-1:0][SPEED_W-1:0] tgt, spd;
   logic [WHEELS-1:0][CMP_W-1:0]   fwd, rev;
   logic signed [ODO_W-1:0]        distance;

   // configuration
   always_comb begin
      kp_in   = kp_ff;
      kd_in   = kd_ff;
      lim_in  = lim_ff;
      revm_in = revm_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_KP:   kp_in   = csr_wdata[GAIN_W-1:0];
            REG_KD:   kd_in   = csr_wdata[GAIN_W-1:0];
            REG_LIM:  lim_in  = csr_wdata[LIM_W-1:0];
            REG_REVM: revm_in = csr_wdata[WHEELS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= KP_RESET;
         kd_ff   <= KD_RESET;
         lim_ff  <= LIM_RESET;
         revm_ff <= REVM_RESET;
      end else begin
         kp_ff   <= kp_in;
         kd_ff   <= kd_in;
         lim_ff  <= lim_in;
         revm_ff <= revm_in;
      end
   end

   // pipeline flow control
   always_comb begin
      rdy[STAGES] = !v_ff[STAGES] || rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      ld[1] = req_valid && rdy[1];
      for (int k = 2; k <= STAGES; k++) begin
         ld[k] = v_ff[k-1] && rdy[k];
      end
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = ld[k] || (v_ff[k] && !rdy[k+1]);
      end
      v_in[STAGES] = ld[STAGES] || (v_ff[STAGES] && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         cmd_ff[1] <= req_data.command;
      end
      for (int k = 2; k < STAGES; k++) begin
         if (ld[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
         end
      end
   end

   always_comb begin
      ctl.ld     = ld;
      ctl.cmd[0] = req_data.command;
      for (int k = 1; k < STAGES; k++) begin
         ctl.cmd[k] = cmd_ff[k];
      end
   end

   assign tgt[0] = req_data.set_lf;
   assign tgt[1] = req_data.set_rf;
   assign tgt[2] = req_data.set_lr;
   assign tgt[3] = req_data.set_rr;
   assign spd[0] = req_data.meas_lf;
   assign spd[1] = req_data.meas_rf;
   assign spd[2] = req_data.meas_lr;
   assign spd[3] = req_data.meas_rr;

   for (genvar w = 0; w < WHEELS; w++) begin : g_lane
      fwpd_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .kp_gain      (kp_ff),
         .kd_gain      (kd_ff),
         .duty_lim     (lim_ff),
         .rev_bit      (revm_ff[w]),
         .set_val      ($signed(tgt[w])),
         .speed        ($signed(spd[w])),
         .fwd          (fwd[w]),
         .rev          (rev[w])
      );
   end

   fwpd_odo u_odo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .speed    (spd),
      .distance (distance)
   );

   assign req_ready = rdy[1];
   assign rsp_valid = v_ff[STAGES];

   always_comb begin
      rsp_data.fwd_lf   = fwd[0];
      rsp_data.rev_lf   = rev[0];
      rsp_data.fwd_rf   = fwd[1];
      rsp_data.rev_rf   = rev[1];
      rsp_data.fwd_lr   = fwd[2];
      rsp_data.rev_lr   = rev[2];
      rsp_data.fwd_rr   = fwd[3];
      rsp_data.rev_rr   = rev[3];
      rsp_data.distance = distance;
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for four_wheel_pd_speed_loop. A class tracks the
// PD controller state, duties and odometer per accepted command, and
// compares every result item field by field. Directed commands cover the
// field extremes, raw duties, both clear commands and the register
// extremes; random phases follow under varied gains, limits and masks.
// ----------------------------------------------------------------------------
module testbench;
   import fwpd_pkg::*;

   class speed_loop_model;
      logic [GAIN_W-1:0] kp, kd;
      logic [LIM_W-1:0]  limit;
      logic [WHEELS-1:0] rev_mask;
      longint            last_err[WHEELS];
      longint            ctrl_acc[WHEELS];
      longint            duty[WHEELS];
      logic [ODO_W-1:0]  odo;
      fwpd_rsp_type      expected_pwm[$];
      int                bad_fields;
      string             cmp_name[8];

      function new();
         kp       = KP_RESET;
         kd       = KD_RESET;
         limit    = LIM_RESET;
         rev_mask = REVM_RESET;
         odo      = '0;
         bad_fields = 0;
         for (int w = 0; w < WHEELS; w++) begin
            last_err[w] = 0;
            ctrl_acc[w] = 0;
            duty[w]     = 0;
         end
         cmp_name = '{"rev_rr", "fwd_rr", "rev_lr", "fwd_lr",
                      "rev_rf", "fwd_rf", "rev_lf", "fwd_lf"};
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            REG_KP:   kp       = data[GAIN_W-1:0];
            REG_KD:   kd       = data[GAIN_W-1:0];
            REG_LIM:  limit    = data[LIM_W-1:0];
            REG_REVM: rev_mask = data[WHEELS-1:0];
            default: ;
         endcase
      endfunction

      function void drive_wheel(int w, longint d);
         if (rev_mask[w])
            d = -d;
         if (d > DUTY_MAX)
            d = DUTY_MAX;
         if (d < -DUTY_MAX)
            d = -DUTY_MAX;
         duty[w] = d;
      endfunction

      function void note_command(fwpd_req_type r);
         longint       tgt[WHEELS];
         longint       spd[WHEELS];
         longint       err, raw, step, acc, limq, d, sum;
         fwpd_rsp_type e;
         tgt = '{r.set_lf, r.set_rf, r.set_lr, r.set_rr};
         spd = '{r.meas_lf, r.meas_rf, r.meas_lr, r.meas_rr};
         case (r.command)
            CMD_TICK: begin
               limq = longint'(limit) * 1024;
               sum  = 0;
               for (int w = 0; w < WHEELS; w++) begin
                  err  = tgt[w] - spd[w];
                  raw  = longint'(kp) * err + longint'(kd) * (err - last_err[w]);
                  step = (raw >= 0) ? ((raw + 128) >>> 8) : -(((-raw) + 128) >>> 8);
                  acc  = ctrl_acc[w] + step;
                  if (acc > limq)
                     acc = limq;
                  if (acc < -limq)
                     acc = -limq;
                  last_err[w] = err;
                  ctrl_acc[w] = acc;
                  d = (acc >= 0) ? (acc >>> 10) : -((-acc) >>> 10);
                  drive_wheel(w, d);
                  sum += spd[w];
               end
               odo = odo + sum[ODO_W-1:0];
            end
            CMD_RAW: begin
               for (int w = 0; w < WHEELS; w++)
                  drive_wheel(w, tgt[w]);
            end
            CMD_CLR_CTRL: begin
               for (int w = 0; w < WHEELS; w++) begin
                  last_err[w] = 0;
                  ctrl_acc[w] = 0;
               end
            end
            default: odo = '0;
         endcase
         e.fwd_lf = (duty[0] > 0) ? CMP_W'(duty[0]) : '0;
         e.rev_lf = (duty[0] < 0) ? CMP_W'(-duty[0]) : '0;
         e.fwd_rf = (duty[1] > 0) ? CMP_W'(duty[1]) : '0;
         e.rev_rf = (duty[1] < 0) ? CMP_W'(-duty[1]) : '0;
         e.fwd_lr = (duty[2] > 0) ? CMP_W'(duty[2]) : '0;
         e.rev_lr = (duty[2] < 0) ? CMP_W'(-duty[2]) : '0;
         e.fwd_rr = (duty[3] > 0) ? CMP_W'(duty[3]) : '0;
         e.rev_rr = (duty[3] < 0) ? CMP_W'(-duty[3]) : '0;
         e.distance = odo;
         expected_pwm.push_back(e);
      endfunction

      function void flag(string what, longint want, longint got);
         bad_fields++;
         if (bad_fields <= 10)
            $display("%0t: mismatch %s expected %0d actual %0d", $time, what, want, got);
      endfunction

      function void check_pwm(fwpd_rsp_type got);
         fwpd_rsp_type      e;
         logic [7:0][9:0]   want_cmp, got_cmp;
         if (expected_pwm.size() == 0) begin
            bad_fields++;
            if (bad_fields <= 10)
               $display("%0t: result item with nothing expected", $time);
            return;
         end
         e = expected_pwm.pop_front();
         want_cmp = {e.fwd_lf, e.rev_lf, e.fwd_rf, e.rev_rf,
                     e.fwd_lr, e.rev_lr, e.fwd_rr, e.rev_rr};
         got_cmp  = {got.fwd_lf, got.rev_lf, got.fwd_rf, got.rev_rf,
                     got.fwd_lr, got.rev_lr, got.fwd_rr, got.rev_rr};
         for (int i = 0; i < 8; i++)
            if (got_cmp[i] !== want_cmp[i])
               flag(cmp_name[i], want_cmp[i], got_cmp[i]);
         if (got.distance !== e.distance)
            flag("distance", e.distance, got.distance);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   fwpd_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   fwpd_rsp_type          rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_wdata;

   speed_loop_model       loop_model;
   bit                    steady;
   int                    aim[WHEELS];

   four_wheel_pd_speed_loop u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 36);
   endfunction

   function automatic int span_val(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic fwpd_req_type make_req(logic [CMD_W-1:0] cmd, int s0, int s1,
                                             int s2, int s3, int v0, int v1,
                                             int v2, int v3);
      fwpd_req_type r;
      r.command  = cmd;
      r.set_lf   = SPEED_W'(s0);
      r.set_rf   = SPEED_W'(s1);
      r.set_lr   = SPEED_W'(s2);
      r.set_rr   = SPEED_W'(s3);
      r.meas_lf  = SPEED_W'(v0);
      r.meas_rf  = SPEED_W'(v1);
      r.meas_lr  = SPEED_W'(v2);
      r.meas_rr  = SPEED_W'(v3);
      return r;
   endfunction

   function automatic fwpd_req_type noise_req(logic [CMD_W-1:0] cmd);
      return make_req(cmd, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic fwpd_req_type random_req();
      int pick;
      int s[WHEELS];
      int v[WHEELS];
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
         if ($urandom_range(0, 9) == 0)
            return noise_req(CMD_TICK);
         for (int w = 0; w < WHEELS; w++) begin
            if ($urandom_range(0, 99) < 15)
               aim[w] = span_val(3000);
            s[w] = aim[w];
            v[w] = aim[w] + span_val(400);
         end
         return make_req(CMD_TICK, s[0], s[1], s[2], s[3], v[0], v[1], v[2], v[3]);
      end
      if (pick < 88) begin
         if ($urandom_range(0, 2) == 0)
            return noise_req(CMD_RAW);
         return make_req(CMD_RAW, span_val(1100), span_val(1100), span_val(1100),
                         span_val(1100), $urandom, $urandom, $urandom, $urandom);
      end
      if (pick < 95)
         return noise_req(CMD_CLR_CTRL);
      return noise_req(CMD_CLR_ODO);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2, 3:    return GAIN_W'($urandom_range(0, 1024));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [LIM_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return LIM_W'(DUTY_MAX);
         2:       return LIM_W'($urandom_range(1001, 1023));
         default: return LIM_W'($urandom_range(0, DUTY_MAX));
      endcase
   endfunction

   task automatic send_command(fwpd_req_type r);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      loop_model.note_command(r);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      loop_model.write_reg(idx, data);
   endtask

   task automatic set_gains(logic [CSR_DAT_W-1:0] kp, logic [CSR_DAT_W-1:0] kd,
                            logic [CSR_DAT_W-1:0] lim, logic [CSR_DAT_W-1:0] revm);
      write_csr(REG_KP, kp);
      write_csr(REG_KD, kd);
      write_csr(REG_LIM, lim);
      write_csr(REG_REVM, revm);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (loop_model.expected_pwm.size() != 0)
         @(posedge clock);
   endtask

   // response side
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready)
            loop_model.check_pwm(rsp_data);
         rsp_ready <= !reset && !take_break();
      end
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      loop_model   = new();
      steady       = 1'b0;
      for (int w = 0; w < WHEELS; w++)
         aim[w] = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset
      send_command(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, -32768));
      send_command(make_req(CMD_TICK, -32768, -32768, -32768, -32768,
                            32767, 32767, 32767, 32767));
      send_command(make_req(CMD_CLR_CTRL, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 1024, -1024, 512, -3, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 1024, -1024, 512, -3, 0, 0, 0, 0));
      send_command(make_req(CMD_RAW, -32768, 32767, 0, -1, 5, 6, 7, 8));
      send_command(make_req(CMD_RAW, 1000, -1000, 1001, -999, 0, 0, 0, 0));
      send_command(make_req(CMD_CLR_ODO, -1, -1, -1, -1, -1, -1, -1, -1));
      send_command(make_req(CMD_TICK, 0, 0, 0, 0, -32768, -32768, -32768, -32768));
      send_command(make_req(CMD_CLR_ODO, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      // register extremes
      set_gains(16'hFFFF, 16'hFFFF, 16'd1023, 16'hF);
      send_command(make_req(CMD_TICK, 100, -100, 1, -1, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 32767, -32768, 0, 0, -32768, 32767, 0, 0));
      send_command(make_req(CMD_RAW, 1023, -1023, -32768, 32767, 0, 0, 0, 0));
      send_command(make_req(CMD_CLR_CTRL, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 5, -5, 0, 2000, 0, 0, 0, 0));
      drain();
      set_gains(16'd0, 16'd0, 16'd0, 16'd0);
      send_command(make_req(CMD_TICK, 32767, -32768, 1000, -1000, 0, 0, 0, 0));
      send_command(make_req(CMD_RAW, 700, -700, -32768, 32767, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 1, 2, 3, 4, 4, 3, 2, 1));
      drain();
      set_gains(16'd25600, 16'd0, 16'd0, 16'd5);
      send_command(make_req(CMD_TICK, 30000, -30000, 30000, -30000, 0, 0, 0, 0));
      send_command(make_req(CMD_TICK, 10, 20, 30, 40, 0, 0, 0, 0));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5)
            set_gains(pick_gain(), pick_gain(),
                      {6'($urandom), pick_limit()}, {12'($urandom), 4'($urandom)});
         else
            set_gains(pick_gain(), pick_gain(), pick_limit(), 4'($urandom));
         steady = (phase == 2);
         for (int n = 0; n < 200; n++)
            send_command(random_req());
         drain();
      end
      steady = 1'b0;

      repeat (20) @(posedge clock);
      if (loop_model.bad_fields == 0 && loop_model.expected_pwm.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
